// File: sv/bdt_pkg.sv
// ---------------------------------------------------------------------------
// bdt_pkg: shared constants, tables and types for the bearing/distance block
// Holds the arctangent table, the CORDIC gain and the side-band item type.
// ---------------------------------------------------------------------------
`default_nettype none

package bdt_pkg;

  localparam int COORD_BITS_DEF    = 20;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int FRAC_BITS    = 16;
  localparam int HEAD_BITS    = 16;
  localparam int DIST_BITS    = 21;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [63:0] KINF_Q32  = 64'd2608131496;
  localparam logic [63:0] KCORR_Q32 = 64'd1738754331;

  // atan(2^-i) as a Q32 fraction of a full turn, truncated
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2F9;
      15:      a = 32'h0000_517C;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A2F;
      19:      a = 32'h0000_0517;
      20:      a = 32'h0000_028B;
      21:      a = 32'h0000_0145;
      22:      a = 32'h0000_00A2;
      23:      a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // Q32 inverse CORDIC gain for a given number of micro-rotations
  function automatic logic [31:0] gain_q32(input int stages);
    int          sh;
    logic [63:0] corr;
    sh   = 2 * stages;
    corr = 64'd0;
    if (sh < 63) begin
      corr = (KCORR_Q32 + (64'd1 << (sh - 1))) >> sh;
    end
    return 32'(KINF_Q32 + corr);
  endfunction

  typedef struct packed {
    logic                 kind;
    logic [HEAD_BITS-1:0] start_heading;
    logic [HEAD_BITS-1:0] target_heading;
    logic                 zero;
  } bdt_side_t;

endpackage

`default_nettype wire

// File: sv/bdt_front.sv
// ---------------------------------------------------------------------------
// bdt_front: offset and half-plane pre-rotation
// Forms dx/dy, then folds the left half plane onto the right one.
// ---------------------------------------------------------------------------
`default_nettype none

module bdt_front import bdt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DATA_W     = COORD_BITS_DEF + FRAC_BITS + 4
) (
  input  wire logic                        clk,
  input  wire logic                        en_diff,
  input  wire logic                        en_rot,
  input  wire logic                        kind,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic        [HEAD_BITS-1:0]  start_heading,
  input  wire logic signed [COORD_BITS-1:0] target_x,
  input  wire logic signed [COORD_BITS-1:0] target_y,
  input  wire logic        [HEAD_BITS-1:0]  target_heading,
  output logic signed [DATA_W-1:0]         x_out,
  output logic signed [DATA_W-1:0]         y_out,
  output logic        [31:0]               z_out,
  output bdt_side_t                        side_out
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  bdt_side_t                  side_d;

  logic signed [DATA_W-1:0] dx_w;
  logic signed [DATA_W-1:0] dy_w;
  logic                     neg;

  // offset stage
  always_ff @(posedge clk) begin
    if (en_diff) begin
      dx <= {target_x[COORD_BITS-1], target_x} - {start_x[COORD_BITS-1], start_x};
      dy <= {target_y[COORD_BITS-1], target_y} - {start_y[COORD_BITS-1], start_y};
      side_d.kind           <= kind;
      side_d.start_heading  <= start_heading;
      side_d.target_heading <= target_heading;
      side_d.zero           <= (target_x == start_x) && (target_y == start_y);
    end
  end

  always_comb begin
    dx_w = {{(DATA_W-COORD_BITS-1){dx[COORD_BITS]}}, dx} <<< FRAC_BITS;
    dy_w = {{(DATA_W-COORD_BITS-1){dy[COORD_BITS]}}, dy} <<< FRAC_BITS;
    neg  = dy[COORD_BITS];
  end

  // pre-rotation stage: rotate by half a turn when dy is negative
  always_ff @(posedge clk) begin
    if (en_rot) begin
      x_out    <= neg ? -dy_w : dy_w;
      y_out    <= neg ? -dx_w : dx_w;
      z_out    <= neg ? HALF_TURN : 32'h0;
      side_out <= side_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/bdt_cell.sv
// ---------------------------------------------------------------------------
// bdt_cell: one CORDIC vectoring micro-rotation
// Drives y towards zero by a fixed angle step and hands the result on.
// ---------------------------------------------------------------------------
`default_nettype none

module bdt_cell import bdt_pkg::*; #(
  parameter int DATA_W = COORD_BITS_DEF + FRAC_BITS + 4,
  parameter int IDX    = 0
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DATA_W-1:0] x_in,
  input  wire logic signed [DATA_W-1:0] y_in,
  input  wire logic        [31:0]       z_in,
  input  wire bdt_side_t                side_in,
  output logic signed [DATA_W-1:0]      x_out,
  output logic signed [DATA_W-1:0]      y_out,
  output logic        [31:0]            z_out,
  output bdt_side_t                     side_out
);

  localparam logic [31:0] ATAN = atan_turn(IDX);

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic signed [DATA_W-1:0] x_next;
  logic signed [DATA_W-1:0] y_next;
  logic        [31:0]       z_next;

  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!y_in[DATA_W-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/bdt_back.sv
// ---------------------------------------------------------------------------
// bdt_back: gain compensation, rounding and turn wrapping
// Scales the CORDIC magnitude, rounds the bearing and forms both turns.
// ---------------------------------------------------------------------------
`default_nettype none

module bdt_back import bdt_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int DATA_W        = COORD_BITS_DEF + FRAC_BITS + 4
) (
  input  wire logic                     clk,
  input  wire logic                     en_mul,
  input  wire logic                     en_out,
  input  wire logic signed [DATA_W-1:0] x_in,
  input  wire logic        [31:0]       z_in,
  input  wire bdt_side_t                side_in,
  output logic signed [HEAD_BITS-1:0]   first_turn,
  output logic        [DIST_BITS-1:0]   distance,
  output logic signed [HEAD_BITS-1:0]   final_turn
);

  localparam int UW = (DATA_W - 1 > 33) ? DATA_W - 1 : 33;
  localparam int HW = UW - 32;
  localparam int PW = HW + 32;
  localparam int TW = PW + 2;

  localparam logic [31:0]   GAIN     = gain_q32(CORDIC_STAGES);
  localparam logic [31:0]   ROUND_Z  = 32'h1 << (31 - ANGLE_BITS);
  localparam logic [TW-1:0] ROUND_D  = {{(TW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [TW-1:0] DIST_TOP = {{(TW-DIST_BITS){1'b0}}, {DIST_BITS{1'b1}}};

  // multiply stage
  logic [UW-1:0]         ux;
  logic [63:0]           lo_prod;
  logic [PW-1:0]         hi_prod;
  logic [31:0]           zr;

  logic [31:0]           lo_hi;
  logic [PW-1:0]         hi_p;
  logic [ANGLE_BITS-1:0] bear;
  bdt_side_t             side_m;

  always_comb begin
    ux      = x_in[DATA_W-1] ? '0 : UW'(x_in[DATA_W-2:0]);
    lo_prod = {32'h0, ux[31:0]} * {32'h0, GAIN};
    hi_prod = PW'(ux[UW-1:32]) * PW'(GAIN);
    zr      = z_in + ROUND_Z;
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      lo_hi  <= lo_prod[63:32];
      hi_p   <= hi_prod;
      bear   <= zr[31 -: ANGLE_BITS];
      side_m <= side_in;
    end
  end

  // rounding and turn stage
  logic [TW-1:0]                    t_sum;
  logic [TW-1:0]                    dq;
  logic [DIST_BITS-1:0]             dist_v;
  logic [ANGLE_BITS+HEAD_BITS-1:0]  sh_ext;
  logic [ANGLE_BITS+HEAD_BITS-1:0]  th_ext;
  logic [ANGLE_BITS-1:0]            sh_a;
  logic [ANGLE_BITS-1:0]            th_a;
  logic [ANGLE_BITS-1:0]            bsel;
  logic [ANGLE_BITS-1:0]            ft;
  logic [ANGLE_BITS-1:0]            fn;
  logic [ANGLE_BITS+HEAD_BITS-1:0]  ft_ext;
  logic [ANGLE_BITS+HEAD_BITS-1:0]  fn_ext;

  always_comb begin
    t_sum = TW'(hi_p) + TW'(lo_hi);
    dq    = (t_sum + ROUND_D) >> FRAC_BITS;
    if (side_m.zero) begin
      dist_v = '0;
    end else if (dq > DIST_TOP) begin
      dist_v = '1;
    end else begin
      dist_v = dq[DIST_BITS-1:0];
    end

    sh_ext = {{ANGLE_BITS{1'b0}}, side_m.start_heading};
    th_ext = {{ANGLE_BITS{1'b0}}, side_m.target_heading};
    sh_a   = sh_ext[ANGLE_BITS-1:0];
    th_a   = th_ext[ANGLE_BITS-1:0];
    bsel   = side_m.zero ? sh_a : bear;
    ft     = bsel - sh_a;
    fn     = th_a - bsel;
    ft_ext = {{HEAD_BITS{ft[ANGLE_BITS-1]}}, ft};
    fn_ext = {{HEAD_BITS{fn[ANGLE_BITS-1]}}, fn};
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      distance   <= dist_v;
      first_turn <= ft_ext[HEAD_BITS-1:0];
      final_turn <= side_m.kind ? fn_ext[HEAD_BITS-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// File: sv/bearing_distance_turn.sv
// ---------------------------------------------------------------------------
// bearing_distance_turn: compass bearing, distance and turns to a target
// Pipelined CORDIC vectoring chain from a start pose to a target point.
// ---------------------------------------------------------------------------
// Each request carries a start pose and a target; the block returns the turn
// onto the compass bearing atan2(dx, dy), the rounded straight-line distance
// and, for a pose target, the turn onto the target heading (zero otherwise).
// Turns wrap into [-half turn, +half turn), so an exact half turn reads as
// the negative extreme; a zero offset takes the start heading as bearing and
// gives distance zero. The data path is a chain of CORDIC_STAGES + 4 register
// stages: offset, half-plane pre-rotation, one cell per micro-rotation, the
// gain multiply and the final rounding/output register. A new request is
// taken every cycle while in_ready is high; its result moves through these
// stages in that order and is held on the outputs until it leaves. Each
// stage moves on whenever it is empty or the stage after it moves, so
// bubbles collapse and requests keep flowing into the chain while a result
// waits at the output; in_ready falls only once every stage holds a
// request. There is no state between requests and no configuration.
// ---------------------------------------------------------------------------
`default_nettype none

module bearing_distance_turn import bdt_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         kind,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [HEAD_BITS-1:0]  start_heading,
  input  wire logic signed [COORD_BITS-1:0] target_x,
  input  wire logic signed [COORD_BITS-1:0] target_y,
  input  wire logic signed [HEAD_BITS-1:0]  target_heading,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [HEAD_BITS-1:0]       first_turn,
  output logic        [DIST_BITS-1:0]       distance,
  output logic signed [HEAD_BITS-1:0]       final_turn
);

  // CORDIC word: sign, three guard bits for gain growth, coordinate and fraction
  localparam int DATA_W = COORD_BITS + FRAC_BITS + 4;
  localparam int STAGES = CORDIC_STAGES + 4;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  // Stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[STAGES-1];

  // Valid bits: shift along with the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Data chain between the cells
  logic signed [DATA_W-1:0] cx   [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] cy   [CORDIC_STAGES+1];
  logic        [31:0]       cz   [CORDIC_STAGES+1];
  bdt_side_t                cside[CORDIC_STAGES+1];

  bdt_front #(
    .COORD_BITS (COORD_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .clk            (clk),
    .en_diff        (en[0]),
    .en_rot         (en[1]),
    .kind           (kind),
    .start_x        (start_x),
    .start_y        (start_y),
    .start_heading  (start_heading),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_heading (target_heading),
    .x_out          (cx[0]),
    .y_out          (cy[0]),
    .z_out          (cz[0]),
    .side_out       (cside[0])
  );

  // One micro-rotation cell per CORDIC step
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    bdt_cell #(
      .DATA_W (DATA_W),
      .IDX    (g)
    ) u_cell (
      .clk      (clk),
      .en       (en[g+2]),
      .x_in     (cx[g]),
      .y_in     (cy[g]),
      .z_in     (cz[g]),
      .side_in  (cside[g]),
      .x_out    (cx[g+1]),
      .y_out    (cy[g+1]),
      .z_out    (cz[g+1]),
      .side_out (cside[g+1])
    );
  end

  bdt_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .DATA_W        (DATA_W)
  ) u_back (
    .clk        (clk),
    .en_mul     (en[STAGES-2]),
    .en_out     (en[STAGES-1]),
    .x_in       (cx[CORDIC_STAGES]),
    .z_in       (cz[CORDIC_STAGES]),
    .side_in    (cside[CORDIC_STAGES]),
    .first_turn (first_turn),
    .distance   (distance),
    .final_turn (final_turn)
  );

  // Checks
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted request missing from the first stage");

  a_full_when_stalled : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled while the chain holds a bubble");

  a_hold_before_out : assert property (@(posedge clk) disable iff (rst)
    (v[STAGES-2] && !en[STAGES-1]) |=> v[STAGES-2])
    else $error("request dropped ahead of a stalled output");

endmodule

`default_nettype wire

// File: tb/sv/bearing_distance_turn_tb.sv
// ---------------------------------------------------------------------------
// bearing_distance_turn_tb: self-checking bench for the bearing/distance block
// Drives start poses and targets through the valid/ready request channel,
// predicts bearing turn, distance and final turn with a bit-exact CORDIC model
// held in a small scoreboard, and compares every result in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bearing_distance_turn_tb import bdt_pkg::*;;

  localparam int N_COORD     = 20;
  localparam int N_ANGLE     = 16;
  localparam int N_STAGES    = 16;
  localparam int RANDOM_REQS = 1550;
  localparam int DRAIN_WAIT  = 30;      // longer than the pipeline is deep
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [N_COORD-1:0] C_MIN = 20'h80000;
  localparam logic [N_COORD-1:0] C_MAX = 20'h7FFFF;
  localparam logic [N_COORD-1:0] C_M1  = 20'hFFFFF;
  localparam logic [N_ANGLE-1:0] H_MIN = 16'h8000;
  localparam logic [N_ANGLE-1:0] H_MAX = 16'h7FFF;
  localparam logic [63:0]        DIST_SAT = 64'd2097151;

  // atan(2^-i) as a Q32 fraction of one turn, truncated
  localparam logic [31:0] ARC_STEP [N_STAGES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C
  };

  typedef struct packed {
    logic [N_ANGLE-1:0]   first_turn;
    logic [DIST_BITS-1:0] distance;
    logic [N_ANGLE-1:0]   final_turn;
  } turn_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predict each accepted request, match results in order
  // -------------------------------------------------------------------------
  class turn_scoreboard;
    turn_result_t pending_turns[$];
    int unsigned  errors;

    function new();
      errors = 0;
    endfunction

    function turn_result_t compute_turns(logic pose, logic [N_COORD-1:0] sx,
                                         logic [N_COORD-1:0] sy,
                                         logic [N_ANGLE-1:0] sh,
                                         logic [N_COORD-1:0] tx,
                                         logic [N_COORD-1:0] ty,
                                         logic [N_ANGLE-1:0] th);
      turn_result_t       res;
      longint             dx, dy, xv, yv, xs, ys;
      logic [31:0]        z;
      logic [N_ANGLE-1:0] bearing;
      logic [63:0]        gain, ux, lo, hi, t, d;
      dx = longint'($signed(tx)) - longint'($signed(sx));
      dy = longint'($signed(ty)) - longint'($signed(sy));
      if (dx == 0 && dy == 0) begin
        bearing = sh;
        d       = 64'd0;
      end else begin
        xv = dy * 65536;
        yv = dx * 65536;
        z  = 32'h0;
        // left half plane: turn the vector through half a turn first
        if (xv < 0) begin
          xv = -xv;
          yv = -yv;
          z  = HALF_TURN;
        end
        for (int i = 0; i < N_STAGES; i++) begin
          xs = xv >>> i;
          ys = yv >>> i;
          if (yv >= 0) begin
            xv = xv + ys;
            yv = yv - xs;
            z  = z + ARC_STEP[i];
          end else begin
            xv = xv - ys;
            yv = yv + xs;
            z  = z - ARC_STEP[i];
          end
        end
        z       = z + (32'd1 << (31 - N_ANGLE));
        bearing = z[31:32-N_ANGLE];
        gain = KINF_Q32 + ((KCORR_Q32 + (64'd1 << (2 * N_STAGES - 1))) >> (2 * N_STAGES));
        ux   = (xv < 0) ? 64'd0 : 64'(xv);
        lo   = {32'h0, ux[31:0]};
        hi   = ux >> 32;
        t    = hi * gain + ((lo * gain) >> 32);
        d    = (t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (d > DIST_SAT) begin
          d = DIST_SAT;
        end
      end
      res.first_turn = bearing - sh;
      res.distance   = d[DIST_BITS-1:0];
      res.final_turn = pose ? (th - bearing) : '0;
      return res;
    endfunction

    function void note_request(logic pose, logic [N_COORD-1:0] sx,
                               logic [N_COORD-1:0] sy, logic [N_ANGLE-1:0] sh,
                               logic [N_COORD-1:0] tx, logic [N_COORD-1:0] ty,
                               logic [N_ANGLE-1:0] th);
      pending_turns.push_back(compute_turns(pose, sx, sy, sh, tx, ty, th));
    endfunction

    function void check_result(logic [N_ANGLE-1:0] ft, logic [DIST_BITS-1:0] dist_got,
                               logic [N_ANGLE-1:0] fnt);
      turn_result_t want;
      if (pending_turns.size() == 0) begin
        $display("%0t: result with no request waiting (first_turn %0d, %s %0d, %s %0d)",
                 $time, $signed(ft), "distance", dist_got, "final_turn", $signed(fnt));
        errors++;
        return;
      end
      want = pending_turns.pop_front();
      if (want.first_turn !== ft) begin
        $display("%0t: first_turn expected %0d, actual %0d",
                 $time, $signed(want.first_turn), $signed(ft));
        errors++;
      end
      if (want.distance !== dist_got) begin
        $display("%0t: distance expected %0d, actual %0d", $time, want.distance, dist_got);
        errors++;
      end
      if (want.final_turn !== fnt) begin
        $display("%0t: final_turn expected %0d, actual %0d",
                 $time, $signed(want.final_turn), $signed(fnt));
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block under test
  // -------------------------------------------------------------------------
  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      kind;
  logic signed [N_COORD-1:0] start_x;
  logic signed [N_COORD-1:0] start_y;
  logic signed [N_ANGLE-1:0] start_heading;
  logic signed [N_COORD-1:0] target_x;
  logic signed [N_COORD-1:0] target_y;
  logic signed [N_ANGLE-1:0] target_heading;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [N_ANGLE-1:0] first_turn;
  logic [DIST_BITS-1:0]      distance;
  logic signed [N_ANGLE-1:0] final_turn;

  turn_scoreboard board = new();
  int unsigned    cycle_count = 0;
  int             burst_left  = 0;

  bearing_distance_turn DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .start_x        (start_x),
    .start_y        (start_y),
    .start_heading  (start_heading),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_heading (target_heading),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .first_turn     (first_turn),
    .distance       (distance),
    .final_turn     (final_turn)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bearing_distance_turn_tb: done, errors");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge: note the request first, then
  // check whatever result leaves in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_request(kind, start_x, start_y, start_heading,
                           target_x, target_y, target_heading);
      end
      if (out_valid && out_ready) begin
        board.check_result(first_turn, distance, final_turn);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side: stall on a pattern that changes character every so often
  // -------------------------------------------------------------------------
  int          sink_mode = 0;
  int          sink_left = 0;
  logic [15:0] sink_pattern = 16'hFFFF;

  initial out_ready = 1'b0;

  always @(negedge clk) begin
    logic next_ready;
    if (sink_left == 0) begin
      sink_mode    = $urandom_range(0, 3);
      sink_left    = $urandom_range(32, 300);
      sink_pattern = 16'($urandom) | 16'h0001;
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      0: begin
        next_ready = 1'b1;                        // no back-pressure
      end
      1: begin
        next_ready   = sink_pattern[0];           // rotate a fixed pattern
        sink_pattern = {sink_pattern[0], sink_pattern[15:1]};
      end
      2: begin
        next_ready = ($urandom_range(0, 3) != 0); // mostly ready
      end
      default: begin
        next_ready = ($urandom_range(0, 3) == 0); // mostly stalled
      end
    endcase
    out_ready <= next_ready;
  end

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------

  // Present one request at the falling edge and hold it until it is taken.
  task automatic send_request(input logic pose, input logic [N_COORD-1:0] sx,
                              input logic [N_COORD-1:0] sy,
                              input logic [N_ANGLE-1:0] sh,
                              input logic [N_COORD-1:0] tx,
                              input logic [N_COORD-1:0] ty,
                              input logic [N_ANGLE-1:0] th);
    @(negedge clk);
    in_valid       = 1'b1;
    kind           = pose;
    start_x        = sx;
    start_y        = sy;
    start_heading  = sh;
    target_x       = tx;
    target_y       = ty;
    target_heading = th;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and scramble the idle payload so that it must be ignored.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid       = 1'b0;
      kind           = 1'($urandom);
      start_x        = N_COORD'($urandom);
      start_y        = N_COORD'($urandom);
      start_heading  = N_ANGLE'($urandom);
      target_x       = N_COORD'($urandom);
      target_y       = N_COORD'($urandom);
      target_heading = N_ANGLE'($urandom);
    end
  endtask

  // Bursts of random length, now and then long ones, with gaps between.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 12));
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(100, 250);
      end else begin
        burst_left = $urandom_range(1, 30);
      end
    end else begin
      burst_left = burst_left - 1;
    end
  endtask

  // Pick one of the edge-case coordinates: minimum, maximum, zero or minus one.
  function automatic logic [N_COORD-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return C_M1;
    endcase
  endfunction

  // One random request: mostly wide open coordinates, plus short hops,
  // zero offsets, axis and diagonal moves and runs between edge-case points.
  task automatic send_random_request();
    logic [N_COORD-1:0] sx, sy, tx, ty, dd;
    logic [N_ANGLE-1:0] sh, th;
    logic               pose;
    pose = 1'($urandom);
    sh   = N_ANGLE'($urandom);
    th   = N_ANGLE'($urandom);
    sx   = N_COORD'($urandom);
    sy   = N_COORD'($urandom);
    tx   = N_COORD'($urandom);
    ty   = N_COORD'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        tx = sx + N_COORD'($urandom_range(0, 16)) - N_COORD'(8);
        ty = sy + N_COORD'($urandom_range(0, 16)) - N_COORD'(8);
      end
      6: begin
        tx = sx;
        ty = sy;
      end
      7: begin
        if ($urandom_range(0, 1) == 0) tx = sx;
        else ty = sy;
      end
      8: begin
        sx = pick_coord();
        sy = pick_coord();
        tx = pick_coord();
        ty = pick_coord();
      end
      9: begin
        dd = N_COORD'($urandom_range(1, 200000));
        tx = ($urandom_range(0, 1) == 0) ? sx + dd : sx - dd;
        ty = ($urandom_range(0, 1) == 0) ? sy + dd : sy - dd;
      end
      default: begin
      end
    endcase
    // steer a few headings onto the half-turn tie of the zero-offset case
    if ($urandom_range(0, 15) == 0) th = sh + H_MIN;
    send_request(pose, sx, sy, sh, tx, ty, th);
  endtask

  initial begin : stimulus
    in_valid       = 1'b0;
    kind           = 1'b0;
    start_x        = '0;
    start_y        = '0;
    start_heading  = '0;
    target_x       = '0;
    target_y       = '0;
    target_heading = '0;

    // hold reset, then release it at a falling edge
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero offset, including the half-turn tie on the final turn
    send_request(1'b0, '0, '0, '0, '0, '0, '0);
    send_request(1'b1, 20'd1234, 20'hFFFB3, H_MIN, 20'd1234, 20'hFFFB3, '0);
    send_request(1'b1, 20'd5, 20'd5, H_MAX, 20'd5, 20'd5, H_MIN);
    pace_sender();
    // corner to corner, both ways: longest distance and the left half plane
    send_request(1'b1, C_MIN, C_MIN, '0, C_MAX, C_MAX, H_MAX);
    send_request(1'b1, C_MAX, C_MAX, H_MIN, C_MIN, C_MIN, H_MIN);
    send_request(1'b1, C_MAX, C_MIN, H_MAX, C_MIN, C_MAX, H_MIN);
    send_request(1'b1, C_MIN, C_MAX, H_MIN, C_MAX, C_MIN, H_MAX);
    // full-span axis moves; straight down lands on the half-turn tie
    send_request(1'b0, '0, C_MIN, '0, '0, C_MAX, H_MAX);
    send_request(1'b1, '0, C_MAX, '0, '0, C_MIN, '0);
    send_request(1'b0, C_MIN, '0, '0, C_MAX, '0, H_MIN);
    send_request(1'b0, C_MAX, '0, H_MAX, C_MIN, '0, '0);
    pace_sender();
    // unit offsets round the compass
    send_request(1'b1, '0, '0, '0, 20'd1, '0, '0);
    send_request(1'b1, '0, '0, '0, C_M1, '0, '0);
    send_request(1'b1, '0, '0, '0, '0, 20'd1, '0);
    send_request(1'b1, '0, '0, '0, '0, C_M1, '0);
    send_request(1'b1, '0, '0, '0, 20'd1, C_M1, H_MAX);
    send_request(1'b1, '0, '0, '0, C_M1, C_M1, H_MIN);
    // due east from a quarter-turn heading; point mode ignores target heading
    send_request(1'b1, 20'd100, 20'd200, 16'h4000, 20'd400, 20'd200, 16'hC000);
    send_request(1'b0, 20'd300, C_M1, 16'h1234, 20'd7, 20'd9000, 16'hFEDC);
    pace_sender();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      send_random_request();
      pace_sender();
    end

    @(negedge clk);
    in_valid = 1'b0;

    // let the pipeline drain, then watch a while for stray results
    while (board.pending_turns.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.errors == 0 && board.pending_turns.size() == 0) begin
      $display("bearing_distance_turn_tb: done, clean");
    end else begin
      $display("bearing_distance_turn_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: bearing_distance_turn.f
sv/bdt_pkg.sv
sv/bdt_front.sv
sv/bdt_cell.sv
sv/bdt_back.sv
sv/bearing_distance_turn.sv
tb/sv/bearing_distance_turn_tb.sv
